// File: sv/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// No dependencies; the top level, esd_decode and esd_queue refer to it by scoped names.
`default_nettype none

package esd_pkg;

  // Character codes that the decoder recognises.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_X      = 8'h78;

  // Control codes produced by the letter escapes.
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_ESC = 8'h1B;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  // Digit limits of the numeric escapes.
  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;
  localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;

  // Result queue: room for one waiting result plus the two an item can cause.
  localparam int QDEPTH = 3;
  localparam int QCNT_W = 2;

  // One decoded result.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } result_t;

  // Results caused by one input transaction.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

  // Decoder status seen by the top level.
  typedef struct packed {
    logic in_text;
    logic num_pending;
  } dec_stat_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [QCNT_W-1:0] fill;
  } q_stat_t;

endpackage

`default_nettype wire

// File: sv/esd_if.sv
// Valid/ready channel interfaces for the escape sequence decoder.
// Depends on nothing; used by the queue and the top level.
`default_nettype none

// Input channel: one character of escaped text per transaction.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel: one decoded byte or end marker per transaction.
interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_present;
  logic       out_last;

  modport source (output valid, output out_byte, output out_present, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_present, input out_last,
                  output ready);
endinterface

`default_nettype wire

// File: sv/escape_sequence_decoder.sv
// Top level of the C-style escape sequence decoder.
// Depends on esd_pkg, esd_if, esd_decode and esd_queue.
`default_nettype none

// The decoder takes one character per cycle while its three-entry result queue
// has room for two results, and hands out one result per cycle from that queue
// while the result side is ready; the queue's single output port passes one
// result a cycle. A character causes no result (a backslash, a digit inside a
// number), one result, or two when it ends a number and yields a second result.
// Every string ends with exactly one result flagged last: a bare end marker
// (out_present low) when the final character yields nothing. Decoding starts
// in normal text after reset, with no clearing pass.
module escape_sequence_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);

  esd_pkg::dec_out_t  dec_res;
  esd_pkg::dec_stat_t dec_stat;
  esd_pkg::q_stat_t   q_stat;
  logic               accept;
  logic [1:0]         push;

  // Take a transaction whenever the queue can absorb two results.
  assign in_ch.ready = (q_stat.fill <= esd_pkg::QCNT_W'(esd_pkg::QDEPTH - 2));
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept ? dec_res.count : 2'd0;

  esd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .res     (dec_res),
    .stat    (dec_stat)
  );

  esd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .r0     (dec_res.r0),
    .r1     (dec_res.r1),
    .out_ch (out_ch),
    .stat   (q_stat)
  );

  // The end of a string always returns the decoder to normal text.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |=> dec_stat.in_text && !dec_stat.num_pending)
    else $error("decoder not back in normal text after end of string");

  // The end of a string always yields at least one result.
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.in_last |-> push != 2'd0)
    else $error("end of string produced no result");

  // Input is held off only while results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with an empty result queue");

  // A queued result is accounted for: fill moves by pushes minus pops.
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> q_stat.fill == $past(q_stat.fill) + $past(push)
                           - esd_pkg::QCNT_W'($past(out_ch.valid && out_ch.ready)))
    else $error("result queue fill count out of step");

endmodule

`default_nettype wire

// File: sv/esd_decode.sv
// Escape decoding state and the single-pass logic that turns one character into results.
// Depends on esd_pkg for character codes and the result structs.
`default_nettype none

module esd_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output esd_pkg::dec_out_t      res,
  output esd_pkg::dec_stat_t     stat
);

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX
  } mode_t;

  mode_t      mode_r,  mode_nxt;
  logic [7:0] value_r, value_nxt;
  logic [1:0] count_r, count_nxt;

  logic        is_dec, is_low, is_up, is_oct, is_hex;
  logic [3:0]  hex_val;
  logic        a_v, b_v, c_v;
  logic [7:0]  a_b, b_b;

  // Classify the incoming character as a digit.
  always_comb begin
    is_dec  = (in_byte >= esd_pkg::CH_0)  && (in_byte <= esd_pkg::CH_9);
    is_low  = (in_byte >= esd_pkg::CH_LA) && (in_byte <= esd_pkg::CH_LF);
    is_up   = (in_byte >= esd_pkg::CH_UA) && (in_byte <= esd_pkg::CH_UF);
    is_oct  = (in_byte >= esd_pkg::CH_0)  && (in_byte <= esd_pkg::CH_7);
    is_hex  = is_dec || is_low || is_up;
    hex_val = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
  end

  // Next state and the results of this character. The first result is the
  // character itself, the code of a letter escape or a finished number; the second
  // is the character that ended a number; the flush result only appears alone.
  always_comb begin
    mode_nxt  = mode_r;
    value_nxt = value_r;
    count_nxt = count_r;
    a_v = 1'b0;
    a_b = 8'h00;
    b_v = 1'b0;
    b_b = 8'h00;
    c_v = 1'b0;

    case (mode_r)
      MODE_TEXT: begin
        if (in_byte == esd_pkg::CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          a_v = 1'b1;
          a_b = in_byte;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        a_v      = 1'b1;
        case (in_byte)
          esd_pkg::CH_LA: a_b = esd_pkg::CODE_BEL;
          esd_pkg::CH_B:  a_b = esd_pkg::CODE_BS;
          esd_pkg::CH_E:  a_b = esd_pkg::CODE_ESC;
          esd_pkg::CH_LF: a_b = esd_pkg::CODE_FF;
          esd_pkg::CH_N:  a_b = esd_pkg::CODE_LF;
          esd_pkg::CH_R:  a_b = esd_pkg::CODE_CR;
          esd_pkg::CH_T:  a_b = esd_pkg::CODE_HT;
          esd_pkg::CH_V:  a_b = esd_pkg::CODE_VT;
          esd_pkg::CH_X: begin
            a_v       = 1'b0;
            mode_nxt  = MODE_HEX;
            value_nxt = 8'h00;
            count_nxt = 2'd0;
          end
          default: begin
            if (is_oct) begin
              a_v       = 1'b0;
              mode_nxt  = MODE_OCT;
              value_nxt = {5'b00000, in_byte[2:0]};
              count_nxt = 2'd1;
            end else begin
              a_b = in_byte;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (is_oct) begin
          value_nxt = {value_r[4:0], in_byte[2:0]};
          count_nxt = count_r + 2'd1;
          if (count_nxt >= esd_pkg::OCT_MAX_DIGITS) begin
            a_v      = 1'b1;
            a_b      = value_nxt;
            mode_nxt = MODE_TEXT;
          end
        end else begin
          a_v = 1'b1;
          a_b = value_r;
          if (in_byte == esd_pkg::CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_TEXT;
            b_v      = 1'b1;
            b_b      = in_byte;
          end
        end
      end
      default: begin
        if (is_hex) begin
          value_nxt = {value_r[3:0], hex_val};
          count_nxt = count_r + 2'd1;
          if (count_nxt >= esd_pkg::HEX_MAX_DIGITS) begin
            a_v      = 1'b1;
            a_b      = value_nxt;
            mode_nxt = MODE_TEXT;
          end
        end else begin
          a_v = 1'b1;
          a_b = value_r;
          if (in_byte == esd_pkg::CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_TEXT;
            b_v      = 1'b1;
            b_b      = in_byte;
          end
        end
      end
    endcase

    // Outside a number the accumulator is kept clear.
    if ((mode_nxt == MODE_TEXT) || (mode_nxt == MODE_ESC)) begin
      value_nxt = 8'h00;
      count_nxt = 2'd0;
    end

    // End of string flushes a pending number.
    c_v = in_last && ((mode_nxt == MODE_OCT) || (mode_nxt == MODE_HEX));

    // Pack the results in order.
    res.r0.data    = a_v ? a_b : value_nxt;
    res.r0.present = 1'b1;
    res.r0.last    = 1'b0;
    res.r1.data    = b_b;
    res.r1.present = 1'b1;
    res.r1.last    = 1'b0;
    res.count      = {1'b0, a_v | c_v} + {1'b0, b_v};

    // Mark the final result, or give a bare end marker when there is none.
    if (in_last) begin
      if (res.count == 2'd0) begin
        res.r0.data    = 8'h00;
        res.r0.present = 1'b0;
        res.r0.last    = 1'b1;
        res.count      = 2'd1;
      end else if (res.count == 2'd1) begin
        res.r0.last = 1'b1;
      end else begin
        res.r1.last = 1'b1;
      end
      mode_nxt  = MODE_TEXT;
      value_nxt = 8'h00;
      count_nxt = 2'd0;
    end
  end

  // Decoder state advances on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_TEXT;
      value_r <= 8'h00;
      count_r <= 2'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      value_r <= value_nxt;
      count_r <= count_nxt;
    end
  end

  assign stat.in_text     = (mode_r == MODE_TEXT);
  assign stat.num_pending = (mode_r == MODE_OCT) || (mode_r == MODE_HEX);

endmodule

`default_nettype wire

// File: sv/esd_queue.sv
// Three-entry result queue that drives the result channel from its head entry.
// Depends on esd_pkg for the result struct and depth, and on esd_if for the channel.
`default_nettype none

module esd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push,
  input  wire esd_pkg::result_t  r0,
  input  wire esd_pkg::result_t  r1,
  esd_out_if.source              out_ch,
  output esd_pkg::q_stat_t       stat
);

  esd_pkg::result_t                q_r   [esd_pkg::QDEPTH];
  esd_pkg::result_t                q_nxt [esd_pkg::QDEPTH];
  logic [esd_pkg::QCNT_W-1:0]      fill_r, fill_nxt, base;
  logic                            pop;

  // Head entry goes out when present.
  assign pop                = (fill_r != '0) && out_ch.ready;
  assign out_ch.valid       = (fill_r != '0);
  assign out_ch.out_byte    = q_r[0].data;
  assign out_ch.out_present = q_r[0].present;
  assign out_ch.out_last    = q_r[0].last;

  // Shift down on a pop, then append the new results behind what remains.
  always_comb begin
    base     = fill_r - esd_pkg::QCNT_W'(pop);
    fill_nxt = base + esd_pkg::QCNT_W'(push);
    for (int i = 0; i < esd_pkg::QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i + 1] : q_r[i];
    end
    q_nxt[esd_pkg::QDEPTH - 1] = q_r[esd_pkg::QDEPTH - 1];
    for (int i = 0; i < esd_pkg::QDEPTH; i++) begin
      if ((push != 2'd0) && (base == esd_pkg::QCNT_W'(i))) begin
        q_nxt[i] = r0;
      end
      if ((push == 2'd2) && (base + esd_pkg::QCNT_W'(1) == esd_pkg::QCNT_W'(i))) begin
        q_nxt[i] = r1;
      end
    end
  end

  // Fill count is control state; the entries carry payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < esd_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign stat.fill = fill_r;

endmodule

`default_nettype wire
